@@ rtl/core/biq_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Cascaded biquad IIR filter package
// Shared constants, command and register codes, and payload types.
// ============================================================================
package biq_pkg;

    localparam int MAX_SECTIONS    = 16;
    localparam int SAMPLE_BITS     = 24;
    localparam int COEFF_FRAC_BITS = 20;

    localparam int CMD_W      = 2;
    localparam int SEC_IDX_W  = 4;
    localparam int SEL_W      = 2;
    localparam int COEFF_W    = 24;
    localparam int HIST_W     = 32;
    localparam int NSEC_W     = 5;
    localparam int GAIN_W     = 24;
    localparam int SHIFT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int PROD_W = COEFF_W + HIST_W;
    localparam int ACC_W  = ((COEFF_W > COEFF_FRAC_BITS) ? COEFF_W : COEFF_FRAC_BITS)
                            + HIST_W + 3;
    localparam int GP_W   = HIST_W + GAIN_W + 1;

    localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) << (COEFF_FRAC_BITS - 1);

    localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COEF   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SECTIONS_USED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MANTISSA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SHIFT    = 2'd2;

    localparam logic [NSEC_W-1:0]  SECTIONS_USED_RST = 5'd1;
    localparam logic [GAIN_W-1:0]  GAIN_MANTISSA_RST = 24'd8388608;
    localparam logic [SHIFT_W-1:0] GAIN_SHIFT_RST    = 6'd23;

    typedef struct packed {
        logic [CMD_W-1:0]              cmd;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_end;
        logic [SEC_IDX_W-1:0]          section_index;
        logic [SEL_W-1:0]              coeff_select;
        logic signed [COEFF_W-1:0]     coeff_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          block_end_out;
        logic                          saturated;
    } out_item_t;

    typedef struct packed {
        logic                      valid;
        logic signed [HIST_W-1:0]  y;
    } biq_tok_t;

    typedef struct packed {
        logic                      clear;
        logic                      coef_we;
        logic [SEL_W-1:0]          coef_sel;
        logic signed [COEFF_W-1:0] coef_val;
    } biq_ctl_t;

endpackage

@@ rtl/core/biq_section_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Biquad section cell
// One second-order section: four coefficients, two input and two output
// history words, and a multiplier that accumulates one product per cycle.
// ============================================================================
module biq_section_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  biq_pkg::biq_ctl_t  ctl,
    input  biq_pkg::biq_tok_t  tok_in,
    output biq_pkg::biq_tok_t  tok_out
);
    import biq_pkg::*;

    logic signed [COEFF_W-1:0] coef_reg [4];
    logic signed [COEFF_W-1:0] coef_next [4];
    logic signed [HIST_W-1:0]  hist_reg [4];
    logic signed [HIST_W-1:0]  hist_next [4];
    logic signed [HIST_W-1:0]  x_reg, x_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic                      busy_reg, busy_next;
    logic [1:0]                ph_reg, ph_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [HIST_W-1:0]  out_y_reg, out_y_next;

    logic signed [ACC_W-1:0]   acc_fin;
    logic signed [ACC_W-1:0]   y_wide;
    logic                      y_ovf;
    logic signed [HIST_W-1:0]  y_sat;

    always_comb begin
        coef_next      = coef_reg;
        hist_next      = hist_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        busy_next      = busy_reg;
        ph_next        = ph_reg;
        out_valid_next = 1'b0;
        out_y_next     = out_y_reg;
        prod_next      = coef_reg[ph_reg] * hist_reg[ph_reg];

        acc_fin = acc_reg - ACC_W'(prod_reg);
        y_wide  = acc_fin >>> COEFF_FRAC_BITS;
        y_ovf   = !(&y_wide[ACC_W-1:HIST_W-1]) && (|y_wide[ACC_W-1:HIST_W-1]);
        y_sat   = y_ovf ? {y_wide[ACC_W-1], {(HIST_W-1){~y_wide[ACC_W-1]}}}
                        : y_wide[HIST_W-1:0];

        if (ctl.coef_we) begin
            coef_next[ctl.coef_sel] = ctl.coef_val;
        end
        if (ctl.clear) begin
            for (int k = 0; k < 4; k++) begin
                hist_next[k] = '0;
            end
        end

        if (!busy_reg) begin
            if (tok_in.valid) begin
                busy_next = 1'b1;
                ph_next   = 2'd1;
                x_next    = tok_in.y;
                acc_next  = (ACC_W'(tok_in.y) <<< COEFF_FRAC_BITS) + ROUND_C;
            end
        end else begin
            ph_next = ph_reg + 2'd1;
            case (ph_reg)
                2'd1, 2'd2: acc_next = acc_reg + ACC_W'(prod_reg);
                2'd3:       acc_next = acc_reg - ACC_W'(prod_reg);
                default: begin
                    busy_next      = 1'b0;
                    ph_next        = 2'd0;
                    out_valid_next = 1'b1;
                    out_y_next     = y_sat;
                    hist_next[1]   = hist_reg[0];
                    hist_next[0]   = x_reg;
                    hist_next[3]   = hist_reg[2];
                    hist_next[2]   = y_sat;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        coef_reg  <= coef_next;
        x_reg     <= x_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        out_y_reg <= out_y_next;
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            ph_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                hist_reg[k] <= '0;
            end
        end else begin
            busy_reg      <= busy_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
            hist_reg      <= hist_next;
        end
    end

    assign tok_out.valid = out_valid_reg;
    assign tok_out.y     = out_y_reg;

endmodule

@@ rtl/core/biq_gain_stage.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Biquad output gain stage
// Multiplies the last section output by the gain mantissa, then shifts
// and saturates the product to the sample range.
// ============================================================================
module biq_gain_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  biq_pkg::biq_tok_t                   tok_in,
    input  logic [biq_pkg::GAIN_W-1:0]          gain_mant,
    input  logic [biq_pkg::SHIFT_W-1:0]         gain_shift,
    input  logic                                take,
    output logic                                res_valid,
    output logic signed [biq_pkg::SAMPLE_BITS-1:0] res_sample,
    output logic                                res_sat
);
    import biq_pkg::*;

    logic signed [GP_W-1:0] gprod_reg, gprod_next;
    logic                   valid_reg, valid_next;
    logic signed [GP_W-1:0] shifted;

    always_comb begin
        gprod_next = gprod_reg;
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (tok_in.valid) begin
            gprod_next = GP_W'(tok_in.y) * $signed({1'b0, gain_mant});
            valid_next = 1'b1;
        end

        shifted    = gprod_reg >>> gain_shift;
        res_sat    = !(&shifted[GP_W-1:SAMPLE_BITS-1]) && (|shifted[GP_W-1:SAMPLE_BITS-1]);
        res_sample = res_sat ? {shifted[GP_W-1], {(SAMPLE_BITS-1){~shifted[GP_W-1]}}}
                             : shifted[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        gprod_reg <= gprod_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign res_valid = valid_reg;

endmodule

@@ rtl/core/cascaded_biquad_iir_filter.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Cascaded biquad IIR filter
// Runs samples through a chain of second-order sections with output gain.
// ============================================================================
// Input items arrive on the s_ channel and are one of: filter a sample, write
// one coefficient of one section, or clear the history of every section.
// Coefficient writes and clears take effect at the transfer and give no result.
// A filter item gives one result on the m_ channel.
// Each active section forms its four coefficient products one per cycle in its
// multiplier before its registered result passes on; the first section starts
// at the transfer itself, and the result then passes the gain multiply and the
// output register. s_ready rises again in the same cycle as m_valid.
// One sample is in flight at a time.
// If the receiver stalls, the result waits in the output register while the
// next sample is already accepted and filtered; that sample then waits in the
// gain stage, and s_ready stays low until the output register frees up.
// Reset clears all section history and loads the default configuration.
// Coefficients hold no value after reset until they are written.
// Configuration writes through cfg_we must be made only while no sample is in
// flight.
// ============================================================================
module cascaded_biquad_iir_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  biq_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output biq_pkg::out_item_t                m_data,
    input  logic                              cfg_we,
    input  logic [biq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [biq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import biq_pkg::*;

    logic [NSEC_W-1:0]  sections_used_reg, sections_used_next;
    logic [GAIN_W-1:0]  gain_mant_reg, gain_mant_next;
    logic [SHIFT_W-1:0] gain_shift_reg, gain_shift_next;
    logic               busy_reg, busy_next;
    logic               block_end_reg, block_end_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    logic               accept;
    logic               take;
    logic [SEC_W-1:0]   last_sec;
    biq_tok_t           cell_in [MAX_SECTIONS];
    biq_tok_t           cell_out [MAX_SECTIONS];
    biq_ctl_t           cell_ctl [MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0] tok_vld;
    biq_tok_t           fin_tok;
    logic               res_valid;
    logic signed [SAMPLE_BITS-1:0] res_sample;
    logic               res_sat;

    assign accept = s_valid && s_ready;
    assign s_ready = !busy_reg;

    always_comb begin
        if (sections_used_reg == '0) begin
            last_sec = '0;
        end else if (int'(sections_used_reg) > MAX_SECTIONS) begin
            last_sec = SEC_W'(MAX_SECTIONS - 1);
        end else begin
            last_sec = SEC_W'(sections_used_reg - NSEC_W'(1));
        end
    end

    for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign cell_in[i].valid = accept && (s_data.cmd == CMD_FILTER);
            assign cell_in[i].y     = HIST_W'(s_data.sample_in);
        end else begin : g_link
            assign cell_in[i].valid = cell_out[i-1].valid && (SEC_W'(i) <= last_sec);
            assign cell_in[i].y     = cell_out[i-1].y;
        end

        assign cell_ctl[i].clear    = accept && (s_data.cmd == CMD_CLEAR);
        assign cell_ctl[i].coef_we  = accept && (s_data.cmd == CMD_COEF)
                                      && (32'(s_data.section_index) == i);
        assign cell_ctl[i].coef_sel = s_data.coeff_select;
        assign cell_ctl[i].coef_val = s_data.coeff_value;
        assign tok_vld[i]           = cell_out[i].valid;

        biq_section_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (cell_ctl[i]),
            .tok_in  (cell_in[i]),
            .tok_out (cell_out[i])
        );
    end

    assign fin_tok = cell_out[last_sec];

    biq_gain_stage u_gain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tok_in     (fin_tok),
        .gain_mant  (gain_mant_reg),
        .gain_shift (gain_shift_reg),
        .take       (take),
        .res_valid  (res_valid),
        .res_sample (res_sample),
        .res_sat    (res_sat)
    );

    assign take = res_valid && (!m_valid_reg || m_ready);

    always_comb begin
        sections_used_next = sections_used_reg;
        gain_mant_next     = gain_mant_reg;
        gain_shift_next    = gain_shift_reg;
        busy_next          = busy_reg;
        block_end_next     = block_end_reg;
        m_valid_next       = m_valid_reg;
        m_data_next        = m_data_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_SECTIONS_USED: sections_used_next = cfg_wdata[NSEC_W-1:0];
                CFG_GAIN_MANTISSA: gain_mant_next     = cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_SHIFT:    gain_shift_next    = cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end

        if (accept && (s_data.cmd == CMD_FILTER)) begin
            busy_next      = 1'b1;
            block_end_next = s_data.block_end;
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (take) begin
            busy_next                 = 1'b0;
            m_valid_next              = 1'b1;
            m_data_next.sample_out    = res_sample;
            m_data_next.block_end_out = block_end_reg;
            m_data_next.saturated     = res_sat;
        end
    end

    always_ff @(posedge aclk) begin
        block_end_reg <= block_end_next;
        m_data_reg    <= m_data_next;
        if (!aresetn) begin
            sections_used_reg <= SECTIONS_USED_RST;
            gain_mant_reg     <= GAIN_MANTISSA_RST;
            gain_shift_reg    <= GAIN_SHIFT_RST;
            busy_reg          <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            sections_used_reg <= sections_used_next;
            gain_mant_reg     <= gain_mant_next;
            gain_shift_reg    <= gain_shift_next;
            busy_reg          <= busy_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_single_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({tok_vld, res_valid}))
        else $error("More than one sample in flight in the section chain.");

    a_take_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> busy_reg)
        else $error("Result moved to the output register with no sample in flight.");

    a_filter_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.cmd == CMD_FILTER)) |=> (!s_ready && !res_valid))
        else $error("Input not held off after a sample transfer.");

    a_chain_idle_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (tok_vld == '0))
        else $error("Section token active while the filter is idle.");
`endif

endmodule
